// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/pzta_pkg.sv =====
// ----------------------------------------------------------------------------
// pzta_pkg
// Widths, zone band constants and register addresses of the zone accumulator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pzta_pkg;

  localparam int NUM_ZONES = 7;
  localparam int ZONE_W    = 3;
  localparam int DUR_W     = 16;
  localparam int WATTS_W   = 12;
  localparam int TIME_W    = 32;
  localparam int TP_W      = 11;
  // Wide enough for 4095 * 100 and for 151 * 2047.
  localparam int SCALE_W   = 19;
  localparam int PCT_W     = 8;

  localparam int S_TDATA_W = 48;
  localparam int M_TDATA_W = 24;
  localparam int PADDR_W   = 2;
  localparam int PDATA_W   = 32;

  localparam logic [PCT_W-1:0]   PCT_SCALE = 8'd100;
  localparam logic [DUR_W-1:0]   DUR_MAX   = 16'hFFFF;
  localparam logic [PADDR_W-1:0] ADDR_THRESHOLD = 2'd0;

  // Lower bound of zones 2 through 7 in percent of threshold power.
  localparam logic [PCT_W-1:0] BAND_LOW_PCT [NUM_ZONES-1] =
    '{8'd56, 8'd76, 8'd91, 8'd106, 8'd121, 8'd151};

endpackage

// ===== hdl/pzta_zone_classify.sv =====
// ----------------------------------------------------------------------------
// pzta_zone_classify
// Maps a power sample to zone 1..7 by exact compares against the bands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pzta_zone_classify (
  input  logic [pzta_pkg::WATTS_W-1:0] watts,
  input  logic [pzta_pkg::TP_W-1:0]    threshold_power,
  output logic [pzta_pkg::ZONE_W-1:0]  zone
);
  import pzta_pkg::*;

  logic [SCALE_W-1:0] scaled;

  assign scaled = SCALE_W'(watts) * SCALE_W'(PCT_SCALE);

  // The bands rise monotonically, so the last bound passed names the zone.
  always_comb begin
    logic [SCALE_W-1:0] bound;
    zone = ZONE_W'(1);
    for (int i = 0; i < NUM_ZONES - 1; i++) begin
      bound = SCALE_W'(BAND_LOW_PCT[i]) * SCALE_W'(threshold_power);
      if (scaled >= bound) begin
        zone = ZONE_W'(i + 2);
      end
    end
  end

endmodule

// ===== hdl/power_zone_time_accumulator.sv =====
// ----------------------------------------------------------------------------
// power_zone_time_accumulator
// Classifies power samples into seven zones and accumulates time per zone.
// ----------------------------------------------------------------------------
// Channel   Dir  Handshake          Contents
// s_*       in   tvalid/tready      watts [11:0], now_seconds [43:12]
// m_*       out  tvalid/tready      zone [2:0], zone_seconds [18:3]
// APB       in   psel/penable       threshold_power at byte address 0
//
// One beat per cycle sustained while m_* takes its beats; a sample taken on
// s_* goes to the input register, which feeds the classify and
// saturating-credit logic, which in turn loads the output register.
// Samples with zero watts or zero threshold leave the state alone and give
// no result. A stalled m_* holds its beat; the input register still takes a
// new beat, and further beats wait only when a result is pending behind it.
// Reset clears the threshold, the last zone and all zone totals.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module power_zone_time_accumulator (
  input  logic                            clk,
  input  logic                            rst,
  // watts [11:0], now_seconds [43:12], zero fill [47:44]
  input  logic [pzta_pkg::S_TDATA_W-1:0]  s_tdata,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // zone [2:0], zone_seconds [18:3], zero fill [23:19]
  output logic [pzta_pkg::M_TDATA_W-1:0]  m_tdata,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pzta_pkg::PADDR_W-1:0]    paddr,
  input  logic [pzta_pkg::PDATA_W-1:0]    pwdata,
  output logic [pzta_pkg::PDATA_W-1:0]    prdata,
  output logic                            pready
);
  import pzta_pkg::*;

  logic [TP_W-1:0]    threshold_power;

  logic               s1_valid;
  logic [WATTS_W-1:0] s1_watts;
  logic [TIME_W-1:0]  s1_now;

  logic [TIME_W-1:0]  last_time;
  logic [ZONE_W-1:0]  prev_zone;
  // Mirror of the total of prev_zone, so the credit needs no array read.
  logic [DUR_W-1:0]   prev_dur;
  logic [DUR_W-1:0]   durations [NUM_ZONES];

  logic               out_valid;
  logic [ZONE_W-1:0]  out_zone;
  logic [DUR_W-1:0]   out_seconds;

  logic               s1_active;
  logic               s1_go;
  logic [ZONE_W-1:0]  zone_new;
  logic [TIME_W-1:0]  delta;
  logic [DUR_W-1:0]   room;
  logic [DUR_W-1:0]   credited;
  logic [DUR_W-1:0]   zone_sec_new;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_THRESHOLD) ? PDATA_W'(threshold_power) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold_power <= '0;
    end else if (psel && penable && pwrite && pready && paddr == ADDR_THRESHOLD) begin
      threshold_power <= pwdata[TP_W-1:0];
    end
  end

  // Handshake between the input register and the output register.
  assign s1_active = (s1_watts != '0) && (threshold_power != '0);
  assign s1_go     = s1_valid && (!s1_active || !out_valid || m_tready);
  assign s_tready  = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_watts <= s_tdata[WATTS_W-1:0];
      s1_now   <= s_tdata[WATTS_W +: TIME_W];
    end
  end

  pzta_zone_classify u_classify (
    .watts           (s1_watts),
    .threshold_power (threshold_power),
    .zone            (zone_new)
  );

  // Elapsed time wraps modulo 2^32; nothing is credited before the first sample.
  assign delta    = (prev_zone != '0) ? (s1_now - last_time) : '0;
  assign room     = DUR_MAX - prev_dur;
  assign credited = (delta >= TIME_W'(room)) ? DUR_MAX : (prev_dur + delta[DUR_W-1:0]);

  // When the zone does not change, the result already includes this credit.
  assign zone_sec_new = (zone_new == prev_zone) ? credited
                                                : durations[ZONE_W'(zone_new - 3'd1)];

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_zone <= '0;
      prev_dur  <= '0;
      last_time <= '0;
      for (int i = 0; i < NUM_ZONES; i++) begin
        durations[i] <= '0;
      end
    end else if (s1_go && s1_active) begin
      for (int i = 0; i < NUM_ZONES; i++) begin
        if (prev_zone == ZONE_W'(i + 1)) begin
          durations[i] <= credited;
        end
      end
      prev_zone <= zone_new;
      prev_dur  <= zone_sec_new;
      last_time <= s1_now;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_active) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_active) begin
      out_zone    <= zone_new;
      out_seconds <= zone_sec_new;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {(M_TDATA_W - ZONE_W - DUR_W)'(0), out_seconds, out_zone};

  `include "assert_macros.svh"

  `ASSERT_SAME(a_out_zone_range, clk, rst, m_tvalid,
               (out_zone != '0) && (out_zone <= ZONE_W'(NUM_ZONES)),
               "result zone out of range")
  `ASSERT_SAME(a_out_matches_total, clk, rst, m_tvalid,
               out_seconds == durations[ZONE_W'(out_zone - 3'd1)],
               "pending result disagrees with its zone total")
  `ASSERT_SAME(a_prev_dur_mirror, clk, rst, prev_zone != '0,
               prev_dur == durations[ZONE_W'(prev_zone - 3'd1)],
               "cached total of the last zone is stale")
  `ASSERT_SAME(a_no_zone_no_time, clk, rst, prev_zone == '0,
               (prev_dur == '0) && (durations[0] == '0) && (durations[NUM_ZONES-1] == '0),
               "time credited before any sample")
  `ASSERT_NEXT(a_accept_loads, clk, rst, s_tvalid && s_tready,
               s1_valid, "accepted beat not held in the input register")

endmodule

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Power zone accumulator testbench
// Drives power samples on the input stream and sets the threshold over APB.
// Every accepted sample is run through a behavioral copy of the zone logic,
// and each output beat is checked in order against the queue of predictions.
// A short table of directed samples comes first, with some results written
// out by hand. Random phases follow, with different thresholds and different
// amounts of idling on the input and output streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

  import pzta_pkg::*;

  typedef struct packed {
    logic [2:0]  zone;
    logic [15:0] secs;
  } zone_result_t;

  typedef enum logic [1:0] {ROW_CFG, ROW_SAMPLE, ROW_KNOWN} row_kind_t;

  // val is the watts of a sample row or the threshold of a config row.
  typedef struct packed {
    row_kind_t   kind;
    logic [31:0] val;
    logic [31:0] stamp;
    logic [2:0]  zone;
    logic [15:0] secs;
  } stim_row_t;

  localparam int          ROWS      = 28;
  localparam int unsigned SECS_CAP  = 65535;
  localparam int          SETTLE_CY = 4;

  logic                 clk      = 1'b0;
  logic                 rst      = 1'b1;
  logic [S_TDATA_W-1:0] s_tdata  = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [M_TDATA_W-1:0] m_tdata;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic                 psel     = 1'b0;
  logic                 penable  = 1'b0;
  logic                 pwrite   = 1'b0;
  logic [PADDR_W-1:0]   paddr    = '0;
  logic [PDATA_W-1:0]   pwdata   = '0;
  logic [PDATA_W-1:0]   prdata;
  logic                 pready;

  power_zone_time_accumulator u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // Predicted state of the block.
  int unsigned band_pct [6] = '{56, 76, 91, 106, 121, 151};
  int unsigned thr;
  int unsigned last_stamp;
  bit          seen;
  int unsigned prev_zone;
  int unsigned zone_secs [1:7];

  zone_result_t pending_zones [$];
  zone_result_t want;
  int unsigned  bad_beats;
  int unsigned  src_idle;
  int unsigned  sink_stall;

  stim_row_t dir_rows [ROWS] = '{
    '{ROW_SAMPLE, 500,  5,            3'd0, 16'd0},
    '{ROW_CFG,    100,  0,            3'd0, 16'd0},
    '{ROW_KNOWN,  55,   1000,         3'd1, 16'd0},
    '{ROW_KNOWN,  56,   1010,         3'd2, 16'd0},
    '{ROW_KNOWN,  75,   1020,         3'd2, 16'd10},
    '{ROW_KNOWN,  76,   1030,         3'd3, 16'd0},
    '{ROW_KNOWN,  90,   1033,         3'd3, 16'd3},
    '{ROW_KNOWN,  91,   1040,         3'd4, 16'd0},
    '{ROW_SAMPLE, 0,    1050,         3'd0, 16'd0},
    '{ROW_KNOWN,  105,  1045,         3'd4, 16'd5},
    '{ROW_KNOWN,  106,  1050,         3'd5, 16'd0},
    '{ROW_KNOWN,  120,  1051,         3'd5, 16'd1},
    '{ROW_KNOWN,  121,  1052,         3'd6, 16'd0},
    '{ROW_KNOWN,  150,  1060,         3'd6, 16'd8},
    '{ROW_KNOWN,  151,  1061,         3'd7, 16'd0},
    '{ROW_KNOWN,  4095, 1061,         3'd7, 16'd0},
    '{ROW_KNOWN,  1,    1000,         3'd1, 16'd10},
    '{ROW_KNOWN,  4095, 32'hFFFFFFFF, 3'd7, 16'hFFFF},
    '{ROW_KNOWN,  4095, 0,            3'd7, 16'hFFFF},
    '{ROW_CFG,    2047, 0,            3'd0, 16'd0},
    '{ROW_SAMPLE, 1145, 40,           3'd0, 16'd0},
    '{ROW_SAMPLE, 1147, 45,           3'd0, 16'd0},
    '{ROW_SAMPLE, 4095, 50,           3'd0, 16'd0},
    '{ROW_CFG,    0,    0,            3'd0, 16'd0},
    '{ROW_SAMPLE, 4095, 60,           3'd0, 16'd0},
    '{ROW_CFG,    1,    0,            3'd0, 16'd0},
    '{ROW_SAMPLE, 1,    70,           3'd0, 16'd0},
    '{ROW_SAMPLE, 2,    75,           3'd0, 16'd0}
  };

  task automatic zone_tally_predict(input logic [11:0] w, input logic [31:0] t,
                                    output bit hit, output zone_result_t res);
    int unsigned scaled;
    int unsigned z;
    int unsigned delta;
    int unsigned room;
    hit = 1'b0;
    res = '0;
    if (w == 0 || thr == 0) return;
    scaled = w * 100;
    z = 1;
    for (int i = 0; i < 6; i++)
      if (scaled >= band_pct[i] * thr) z = i + 2;
    delta = seen ? t - last_stamp : 0;
    // Time since the last sample belongs to the zone that held until now.
    if (prev_zone != 0) begin
      room = SECS_CAP - zone_secs[prev_zone];
      zone_secs[prev_zone] = (delta >= room) ? SECS_CAP : zone_secs[prev_zone] + delta;
    end
    prev_zone = z;
    last_stamp = t;
    seen = 1'b1;
    hit = 1'b1;
    res.zone = z[2:0];
    res.secs = zone_secs[z][15:0];
  endtask

  // Called at a rising edge; returns at the edge where the beat was taken.
  task automatic send_sample(input logic [11:0] w, input logic [31:0] t,
                             input bit known, input zone_result_t known_res);
    bit           hit;
    zone_result_t res;
    while ($urandom_range(0, 99) < src_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tdata  <= {4'b0, t, w};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    zone_tally_predict(w, t, hit, res);
    if (hit) pending_zones.push_back(known ? known_res : res);
  endtask

  // Ignored samples give no result, so waiting goes on after the queue is empty.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_zones.size() != 0) @(posedge clk);
    repeat (SETTLE_CY) @(posedge clk);
  endtask

  task automatic write_threshold(input logic [10:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_THRESHOLD;
    pwdata  <= {21'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    thr = value;
  endtask

  // Mostly watts right around a band boundary of the current threshold.
  function automatic logic [11:0] pick_watts();
    int unsigned bound_w;
    if ($urandom_range(0, 9) < 3) return 12'($urandom_range(1, 4095));
    bound_w = (band_pct[$urandom_range(0, 5)] * thr + 99) / 100 + $urandom_range(0, 2);
    if (bound_w > 1) bound_w = bound_w - 1;
    return bound_w[11:0];
  endfunction

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= sink_stall);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_zones.size() == 0) begin
        if (bad_beats < 10)
          $display("unexpected beat: zone %0d secs %0d", m_tdata[2:0], m_tdata[18:3]);
        bad_beats++;
      end else begin
        want = pending_zones.pop_front();
        if (m_tdata[2:0] != want.zone || m_tdata[18:3] != want.secs) begin
          if (bad_beats < 10)
            $display("mismatch: expected zone %0d secs %0d, got zone %0d secs %0d",
                     want.zone, want.secs, m_tdata[2:0], m_tdata[18:3]);
          bad_beats++;
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    int unsigned  goal;
    int unsigned  count;
    int unsigned  sel;
    int unsigned  phase_thr [8];
    logic [11:0]  w;
    logic [31:0]  clock_s;

    thr = 0;
    last_stamp = 0;
    seen = 1'b0;
    prev_zone = 0;
    for (int z = 1; z <= 7; z++) zone_secs[z] = 0;
    bad_beats = 0;
    src_idle = 0;
    sink_stall = 0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int r = 0; r < ROWS; r++) begin
      case (dir_rows[r].kind)
        ROW_CFG: begin
          settle();
          write_threshold(dir_rows[r].val[10:0]);
        end
        ROW_SAMPLE: send_sample(dir_rows[r].val[11:0], dir_rows[r].stamp, 1'b0, '0);
        default: send_sample(dir_rows[r].val[11:0], dir_rows[r].stamp, 1'b1,
                             {dir_rows[r].zone, dir_rows[r].secs});
      endcase
    end

    phase_thr = '{250, 2047, 1, $urandom_range(1, 2047), 0, 40,
                  $urandom_range(1, 2047), 2047};
    clock_s = 75;
    for (int p = 0; p < 8; p++) begin
      settle();
      write_threshold(phase_thr[p][10:0]);
      case (p % 4)
        0: begin src_idle = 0;  sink_stall = 0;  end
        1: begin src_idle = 51; sink_stall = 0;  end
        2: begin src_idle = 0;  sink_stall = 51; end
        default: begin src_idle = 21; sink_stall = 21; end
      endcase
      // A zero threshold phase only shows that every sample is dropped.
      goal = (thr == 0) ? 12 : 127;
      count = 0;
      while (count < goal) begin
        w = ($urandom_range(0, 29) == 0) ? 12'd0 : pick_watts();
        sel = $urandom_range(0, 99);
        if (sel < 90) clock_s = clock_s + $urandom_range(0, 20);
        else if (sel < 98) clock_s = clock_s + $urandom_range(0, 5000);
        else clock_s = $urandom;
        send_sample(w, clock_s, 1'b0, '0);
        if (thr == 0 || w != 0) count++;
      end
    end

    s_tvalid <= 1'b0;
    while (pending_zones.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (bad_beats == 0 && pending_zones.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
